FILE: src/linked_list_deque_engine_unit_assert.svh
// Assertion macros for the deque engine.
// Included by linked_list_deque_engine_unit; no other dependencies.
`ifndef LINKED_LIST_DEQUE_ENGINE_UNIT_ASSERT_SVH
`define LINKED_LIST_DEQUE_ENGINE_UNIT_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define LLDE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define LLDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: src/llde_pkg.sv
// Shared types and constants of the deque engine.
// No dependencies.
package llde_pkg;

    localparam int unsigned POOL_NODES_DEF = 64;
    localparam int unsigned KIND_W         = 3;
    localparam int unsigned VALUE_W        = 32;
    localparam int unsigned HANDLE_W       = 6;
    localparam int unsigned STATUS_W       = 3;
    localparam int unsigned S_TDATA_W      = 40;
    localparam int unsigned M_TDATA_W      = 48;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 3'd0,
        K_PUSH_BACK  = 3'd1,
        K_POP_FRONT  = 3'd2,
        K_POP_BACK   = 3'd3,
        K_INSERT     = 3'd4,
        K_DELETE     = 3'd5,
        K_FIND       = 3'd6,
        K_NOP        = 3'd7
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        S_OK        = 3'd0,
        S_EMPTY     = 3'd1,
        S_FULL      = 3'd2,
        S_BAD       = 3'd3,
        S_NOT_FOUND = 3'd4
    } t_status;

endpackage

FILE: src/linked_list_deque_engine_unit.sv
// Deque engine: doubly linked list in a node pool, node 0 the sentinel.
// Push, insert, pop and delete pass EXEC, LINK and RESP; errors pass EXEC and
// RESP; NOP goes straight to RESP; find walks in FIND (one memory read per node)
// before RESP. One item at a time; the next is taken once the result is queued.
// Reset (synchronous, active low) empties the list; the pool memories need none.
// Depends on llde_pkg and linked_list_deque_engine_unit_assert.svh.
`include "linked_list_deque_engine_unit_assert.svh"

module linked_list_deque_engine_unit #(
    parameter int unsigned POOL_NODES = llde_pkg::POOL_NODES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // value [31:0], handle [37:32], zero fill
    input  logic [llde_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // kind [2:0]
    input  logic [llde_pkg::KIND_W-1:0]     i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // node_handle [5:0], node_value [37:6], element_count [43:38], zero fill
    output logic [llde_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // status [2:0]
    output logic [llde_pkg::STATUS_W-1:0]   o_m_axis_tuser
);
    import llde_pkg::*;

    localparam int unsigned IW = $clog2(POOL_NODES);
    localparam int unsigned FW = IW + 1;
    localparam int unsigned CW = ((IW > HANDLE_W) ? IW : HANDLE_W) + 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXEC, ST_LINK, ST_FIND, ST_RESP
    } t_state;

    // Pool memories
    logic [VALUE_W-1:0] val_mem  [POOL_NODES];
    logic [IW-1:0]      next_mem [POOL_NODES];
    logic [IW-1:0]      prev_mem [POOL_NODES];
    logic               use_mem  [POOL_NODES];

    logic [VALUE_W-1:0] val_q;
    logic [IW-1:0]      next_q, prev_q;
    logic               use_q;

    logic [IW-1:0] ra, rn;
    logic val_we, nx_we, pv_we, use_we, use_wd;
    logic [IW-1:0] val_wa, nx_wa, nx_wd, pv_wa, pv_wd, use_wa;

    // Control and item registers
    t_state             r_state, n_state;
    logic [IW-1:0]      r_snext, n_snext, r_sprev, n_sprev, r_free, n_free;
    logic [IW-1:0]      r_live, n_live;
    logic [FW-1:0]      r_fresh, n_fresh;
    logic [IW-1:0]      r_idx, n_idx, r_node, n_node, r_p, n_p;
    logic               r_rng, n_rng;
    t_kind              r_kind, n_kind;
    logic [VALUE_W-1:0] r_value, n_value, r_rval, n_rval;
    t_status            r_stat, n_stat;
    logic               r_o_valid, n_o_valid;
    logic [M_TDATA_W-1:0] r_o_data, n_o_data;
    logic [STATUS_W-1:0]  r_o_user, n_o_user;

    t_kind              in_kind;
    logic [CW-1:0]      h_w;
    logic               s_acc, fresh_av, use_ok, bad, full, ins_kind;
    logic [IW-1:0]      a_idx, take_n, lnk_p, lnk_q;

    assign in_kind  = t_kind'(i_s_axis_tuser);
    assign h_w      = CW'(i_s_axis_tdata[VALUE_W +: HANDLE_W]);
    assign s_acc    = i_s_axis_tvalid && (r_state == ST_IDLE);
    assign fresh_av = r_fresh < FW'(POOL_NODES);
    assign take_n   = fresh_av ? r_fresh[IW-1:0] : r_free;
    assign use_ok   = (FW'(r_idx) < r_fresh) && use_q;
    assign ins_kind = (r_kind == K_PUSH_FRONT) || (r_kind == K_PUSH_BACK) ||
                      (r_kind == K_INSERT);

    // Issue reads: address from the item on accept, from the next link while walking
    always_comb begin
        a_idx = '0;
        unique case (in_kind)
            K_PUSH_FRONT, K_POP_FRONT, K_FIND: a_idx = r_snext;
            K_POP_BACK:                        a_idx = r_sprev;
            K_INSERT, K_DELETE:                a_idx = h_w[IW-1:0];
            default:                           a_idx = '0;
        endcase
        if (r_state == ST_FIND) begin
            ra = next_q;
            rn = next_q;
        end else begin
            ra = a_idx;
            rn = ((in_kind == K_PUSH_FRONT) || (in_kind == K_PUSH_BACK) ||
                  (in_kind == K_INSERT)) ? r_free : a_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        val_q  <= val_mem[ra];
        prev_q <= prev_mem[ra];
        use_q  <= use_mem[ra];
        next_q <= next_mem[rn];
        if (val_we) val_mem[val_wa] <= r_value;
        if (nx_we)  next_mem[nx_wa] <= nx_wd;
        if (pv_we)  prev_mem[pv_wa] <= pv_wd;
        if (use_we) use_mem[use_wa] <= use_wd;
    end

    // Sequencer: decide, write back links, queue the result
    always_comb begin
        n_state = r_state;  n_snext = r_snext;  n_sprev = r_sprev;
        n_free  = r_free;   n_live  = r_live;   n_fresh = r_fresh;
        n_idx   = r_idx;    n_node  = r_node;   n_p     = r_p;
        n_rng   = r_rng;    n_kind  = r_kind;   n_value = r_value;
        n_rval  = r_rval;   n_stat  = r_stat;
        n_o_valid = r_o_valid && !i_m_axis_tready;
        n_o_data  = r_o_data;
        n_o_user  = r_o_user;
        val_we = 1'b0; val_wa = take_n;
        nx_we = 1'b0;  nx_wa = '0; nx_wd = '0;
        pv_we = 1'b0;  pv_wa = '0; pv_wd = '0;
        use_we = 1'b0; use_wa = '0; use_wd = 1'b0;
        bad = 1'b0; full = 1'b0;
        lnk_p = r_idx == '0 ? r_sprev : prev_q;
        lnk_q = next_q;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_kind  = in_kind;
                    n_value = i_s_axis_tdata[VALUE_W-1:0];
                    n_idx   = a_idx;
                    n_rng   = ((in_kind != K_INSERT) && (in_kind != K_DELETE)) ||
                              (h_w < CW'(POOL_NODES));
                    n_stat  = S_OK;
                    n_node  = '0;
                    n_rval  = '0;
                    if (in_kind == K_NOP)       n_state = ST_RESP;
                    else if (in_kind == K_FIND) n_state = ST_FIND;
                    else                        n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (ins_kind) begin
                    bad  = (r_kind == K_INSERT) && (r_idx != '0) && (!r_rng || !use_ok);
                    full = !fresh_av && (r_free == '0);
                    if (bad) begin
                        n_stat = S_BAD;  n_state = ST_RESP;
                    end else if (full) begin
                        n_stat = S_FULL; n_state = ST_RESP;
                    end else begin
                        // Link the new node between its predecessor and the position
                        val_we = 1'b1;
                        use_we = 1'b1; use_wa = take_n; use_wd = 1'b1;
                        if (lnk_p == '0) n_snext = take_n;
                        else begin
                            nx_we = 1'b1; nx_wa = lnk_p; nx_wd = take_n;
                        end
                        if (r_idx == '0) n_sprev = take_n;
                        else begin
                            pv_we = 1'b1; pv_wa = r_idx; pv_wd = take_n;
                        end
                        if (fresh_av) n_fresh = r_fresh + FW'(1);
                        else          n_free  = next_q;
                        n_live  = r_live + IW'(1);
                        n_node  = take_n;
                        n_p     = lnk_p;
                        n_state = ST_LINK;
                    end
                end else begin
                    if (r_kind == K_DELETE) begin
                        bad = (r_idx == '0) || !r_rng || !use_ok;
                    end else begin
                        bad = r_idx == '0;
                    end
                    if (bad) begin
                        n_stat  = (r_kind == K_DELETE) ? S_BAD : S_EMPTY;
                        n_state = ST_RESP;
                    end else begin
                        // Unlink the node and close the gap
                        if (prev_q == '0) n_snext = lnk_q;
                        else begin
                            nx_we = 1'b1; nx_wa = prev_q; nx_wd = lnk_q;
                        end
                        if (lnk_q == '0) n_sprev = prev_q;
                        else begin
                            pv_we = 1'b1; pv_wa = lnk_q; pv_wd = prev_q;
                        end
                        use_we = 1'b1; use_wa = r_idx; use_wd = 1'b0;
                        n_live  = r_live - IW'(1);
                        n_node  = r_idx;
                        n_rval  = val_q;
                        n_state = ST_LINK;
                    end
                end
            end
            ST_LINK: begin
                if (ins_kind) begin
                    // Own links of the new node
                    nx_we = 1'b1; nx_wa = r_node; nx_wd = r_idx;
                    pv_we = 1'b1; pv_wa = r_node; pv_wd = r_p;
                end else begin
                    // Push the removed node on the free chain
                    nx_we = 1'b1; nx_wa = r_node; nx_wd = r_free;
                    n_free = r_node;
                end
                n_state = ST_RESP;
            end
            ST_FIND: begin
                if (r_idx == '0) begin
                    n_stat = S_NOT_FOUND; n_state = ST_RESP;
                end else if (val_q == r_value) begin
                    n_node = r_idx; n_rval = r_value; n_state = ST_RESP;
                end else begin
                    n_idx = next_q;
                end
            end
            ST_RESP: begin
                if (!r_o_valid || i_m_axis_tready) begin
                    n_o_valid = 1'b1;
                    n_o_user  = r_stat;
                    n_o_data  = {4'b0, HANDLE_W'(CW'(r_live)), r_rval,
                                 HANDLE_W'(CW'(r_node))};
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_snext   <= '0;
            r_sprev   <= '0;
            r_free    <= '0;
            r_live    <= '0;
            r_fresh   <= FW'(1);
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_snext   <= n_snext;
            r_sprev   <= n_sprev;
            r_free    <= n_free;
            r_live    <= n_live;
            r_fresh   <= n_fresh;
            r_o_valid <= n_o_valid;
        end
        r_idx    <= n_idx;
        r_node   <= n_node;
        r_p      <= n_p;
        r_rng    <= n_rng;
        r_kind   <= n_kind;
        r_value  <= n_value;
        r_rval   <= n_rval;
        r_stat   <= n_stat;
        r_o_data <= n_o_data;
        r_o_user <= n_o_user;
    end

    assign o_s_axis_tready = r_state == ST_IDLE;
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tuser  = r_o_user;

    `LLDE_ASSERT_NOW(a_live_le_fresh, i_clk, i_rst_n, 1'b1, FW'(r_live) < r_fresh, "live count exceeds nodes handed out")
    `LLDE_ASSERT_NOW(a_sentinel_pair, i_clk, i_rst_n, 1'b1, (r_snext == '0) == (r_sprev == '0), "sentinel links disagree on empty list")
    `LLDE_ASSERT_NOW(a_empty_count, i_clk, i_rst_n, r_snext == '0, r_live == '0, "empty list with non-zero count")
    `LLDE_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, s_acc, r_state != ST_IDLE, "item finished in the accept cycle")

endmodule

FILE: verif/tb.sv
// Testbench for linked_list_deque_engine_unit: drives list operations over the
// item streams and checks each result against a behavioural deque predictor.
// Depends on llde_pkg and the engine RTL.
`timescale 1ns / 100ps

class deque_scoreboard;
    typedef struct {
        llde_pkg::t_status st;
        logic [5:0]        node;
        logic [31:0]       val;
        logic [5:0]        cnt;
    } t_result;

    // predictor state
    logic [31:0] store_val [64];
    int unsigned nxt_l [64];
    int unsigned prv_l [64];
    bit          used [64];
    int unsigned free_head, fresh_next, live;
    t_result     pending[$];
    int          errors;

    function new();
        free_head = 0; fresh_next = 1; live = 0; errors = 0;
        foreach (used[i]) begin
            used[i] = 0; nxt_l[i] = 0; prv_l[i] = 0; store_val[i] = 0;
        end
    endfunction

    function int unsigned take_node();
        int unsigned n;
        n = 0;
        if (fresh_next < 64) begin
            n = fresh_next;
            fresh_next++;
        end else if (free_head != 0) begin
            n = free_head;
            free_head = nxt_l[n];
        end
        return n;
    endfunction

    function int unsigned link_before(int unsigned pos, logic [31:0] v);
        int unsigned n, p;
        n = take_node();
        if (n == 0) return 0;
        p = prv_l[pos];
        store_val[n] = v;
        used[n] = 1;
        nxt_l[p] = n;
        prv_l[n] = p;
        nxt_l[n] = pos;
        prv_l[pos] = n;
        live++;
        return n;
    endfunction

    function void unlink(int unsigned n);
        int unsigned p, q;
        p = prv_l[n];
        q = nxt_l[n];
        nxt_l[p] = q;
        prv_l[q] = p;
        used[n] = 0;
        nxt_l[n] = free_head;
        free_head = n;
        if (live != 0) live--;
    endfunction

    // note an accepted item and queue its expected result
    function void note_item(llde_pkg::t_kind k, logic [31:0] v, logic [5:0] h);
        t_result r;
        int unsigned n, i;
        r.st = llde_pkg::S_OK; r.node = 0; r.val = 0;
        case (k)
            llde_pkg::K_PUSH_FRONT, llde_pkg::K_PUSH_BACK, llde_pkg::K_INSERT: begin
                n = (k == llde_pkg::K_PUSH_FRONT) ? nxt_l[0] :
                    (k == llde_pkg::K_PUSH_BACK) ? 0 : 32'(h);
                if (n != 0 && !used[n]) r.st = llde_pkg::S_BAD;
                else begin
                    r.node = 6'(link_before(n, v));
                    if (r.node == 0) r.st = llde_pkg::S_FULL;
                end
            end
            llde_pkg::K_POP_FRONT, llde_pkg::K_POP_BACK: begin
                n = (k == llde_pkg::K_POP_FRONT) ? nxt_l[0] : prv_l[0];
                if (n == 0 || !used[n]) r.st = llde_pkg::S_EMPTY;
                else begin
                    r.node = 6'(n); r.val = store_val[n]; unlink(n);
                end
            end
            llde_pkg::K_DELETE: begin
                if (h == 0 || !used[h]) r.st = llde_pkg::S_BAD;
                else begin
                    r.node = h; r.val = store_val[h]; unlink(32'(h));
                end
            end
            llde_pkg::K_FIND: begin
                r.st = llde_pkg::S_NOT_FOUND;
                n = nxt_l[0];
                for (i = 0; i < 64 && n != 0; i++) begin
                    if (store_val[n] == v) begin
                        r.st = llde_pkg::S_OK; r.node = 6'(n); r.val = v;
                        break;
                    end
                    n = nxt_l[n];
                end
            end
            default: ;
        endcase
        r.cnt = 6'(live);
        pending.push_back(r);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(logic [2:0] st, logic [47:0] d);
        t_result r;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result st=%0d data=%h", $time, st, d);
            errors++;
            return;
        end
        r = pending.pop_front();
        if (st !== r.st) begin
            $display("%0t: status exp %0d got %0d", $time, r.st, st); errors++;
        end
        if (d[5:0] !== r.node) begin
            $display("%0t: handle exp %0d got %0d", $time, r.node, d[5:0]); errors++;
        end
        if (d[37:6] !== r.val) begin
            $display("%0t: value exp %h got %h", $time, r.val, d[37:6]); errors++;
        end
        if (d[43:38] !== r.cnt) begin
            $display("%0t: count exp %0d got %0d", $time, r.cnt, d[43:38]); errors++;
        end
        if (d[47:44] !== 4'd0) begin
            $display("%0t: fill exp 0 got %h", $time, d[47:44]); errors++;
        end
    endfunction
endclass

module tb;
    import llde_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [39:0] s_data = '0;
    logic [2:0]  s_user = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [47:0] m_data;
    logic [2:0]  m_user;

    deque_scoreboard board = new();
    bit          quiet_phase = 0;
    bit          hold_off = 0;
    int          idle_cycles = 0;
    logic [31:0] recent_vals[$];

    linked_list_deque_engine_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user)
    );

    always #2 i_clk = ~i_clk;

    // note accepted items, check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n && s_valid && s_ready) begin
            board.note_item(t_kind'(s_user), s_data[31:0], s_data[37:32]);
            recent_vals.push_back(s_data[31:0]);
            if (recent_vals.size() > 16) void'(recent_vals.pop_front());
        end
        if (i_rst_n && m_valid && m_ready) board.check_result(m_user, m_data);
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("tb failed");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off
    initial begin : sink
        int n;
        bit held;
        held = 0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off && !held) begin
                m_ready <= 0;
                repeat (300) @(posedge i_clk);
                held = 1;
            end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                m_ready <= 0;
                n = $urandom_range(1, 7);
                repeat (n) @(posedge i_clk);
            end else begin
                m_ready <= 1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send(t_kind k, logic [31:0] v, logic [5:0] h);
        int n;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            n = $urandom_range(1, 7);
            repeat (n) @(posedge i_clk);
        end
        s_valid <= 1;
        s_user <= k;
        s_data <= {2'b00, h, v};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return (recent_vals.size() != 0) ?
                      recent_vals[$urandom_range(0, recent_vals.size() - 1)] : 0;
            3: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // pick a live handle most of the time, any handle otherwise
    function automatic logic [5:0] rand_handle();
        int unsigned h;
        if ($urandom_range(0, 4) != 0) begin
            repeat (8) begin
                h = $urandom_range(1, 63);
                if (board.used[h]) return 6'(h);
            end
        end
        return 6'($urandom_range(0, 63));
    endfunction

    initial begin : stim
        t_kind k;
        int    i, mode;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: empty pops, bad handles, extremes, no-op kind
        send(K_POP_FRONT, 0, 6'd0);
        send(K_POP_BACK, 0, 6'd0);
        send(K_DELETE, 0, 6'd0);
        send(K_DELETE, 0, 6'd63);
        send(K_INSERT, 0, 6'd5);
        send(K_FIND, 32'h1, 6'd0);
        send(K_PUSH_FRONT, 32'h8000_0000, 6'd0);
        send(K_PUSH_BACK, 32'h7fff_ffff, 6'h3f);
        send(K_INSERT, 32'hffff_ffff, 6'd0);
        send(K_INSERT, 32'h0, 6'd1);
        send(K_FIND, 32'h7fff_ffff, 6'd0);
        send(K_FIND, 32'h1234_5678, 6'd0);
        send(K_NOP, 32'hffff_ffff, 6'h3f);
        send(K_DELETE, 0, 6'd2);
        send(K_DELETE, 0, 6'd2);
        send(K_POP_FRONT, 0, 6'd0);
        send(K_POP_BACK, 0, 6'd0);
        // fill the pool, then overflow it, with the receiver held off
        hold_off = 1;
        for (i = 0; i < 66; i++) send(K_PUSH_BACK, $urandom, 6'd0);
        send(K_INSERT, 1, 6'd0);
        send(K_FIND, board.store_val[63], 6'd0);
        // random phases biased between growing and draining
        for (i = 0; i < 1600; i++) begin
            if (i == 1450) quiet_phase = 1;
            mode = (i / 200) % 2;
            case ($urandom_range(0, 9))
                0, 1: k = mode ? K_PUSH_FRONT : K_POP_FRONT;
                2, 3: k = mode ? K_PUSH_BACK : K_POP_BACK;
                4: k = K_INSERT;
                5: k = K_DELETE;
                6, 7: k = K_FIND;
                8: k = t_kind'($urandom_range(0, 7));
                default: k = mode ? K_INSERT : K_DELETE;
            endcase
            send(k, rand_val(), rand_handle());
        end
        s_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
